// ===== design/gifp_pkg.sv =====
`default_nettype none

package gifp_pkg;

  // event codes carried in tuser
  localparam logic [3:0] EV_NONE        = 4'd0;
  localparam logic [3:0] EV_SCREEN      = 4'd1;
  localparam logic [3:0] EV_GLOBAL_COL  = 4'd2;
  localparam logic [3:0] EV_LOCAL_COL   = 4'd3;
  localparam logic [3:0] EV_GCE         = 4'd4;
  localparam logic [3:0] EV_IMAGE_DESC  = 4'd5;
  localparam logic [3:0] EV_CODE_SIZE   = 4'd6;
  localparam logic [3:0] EV_DATA_BYTE   = 4'd7;
  localparam logic [3:0] EV_FRAME_END   = 4'd8;
  localparam logic [3:0] EV_TRAILER     = 4'd9;
  localparam logic [3:0] EV_BAD_SIG     = 4'd10;
  localparam logic [3:0] EV_NO_TABLE    = 4'd11;
  localparam logic [3:0] EV_BAD_BLOCK   = 4'd12;

  // block introducer and label bytes
  localparam logic [7:0] BYTE_EXT_INTRO = 8'h21;
  localparam logic [7:0] BYTE_GCE_LABEL = 8'hF9;
  localparam logic [7:0] BYTE_IMG_SEP   = 8'h2C;
  localparam logic [7:0] BYTE_TRAILER   = 8'h3B;

  localparam logic [7:0] SIG_0 = 8'h47;  // G
  localparam logic [7:0] SIG_1 = 8'h49;  // I
  localparam logic [7:0] SIG_2 = 8'h46;  // F

  localparam int unsigned TDATA_W = 136;

  typedef struct packed {
    logic        transp_en;
    logic [2:0]  disposal;
    logic [7:0]  transp_idx;
    logic [15:0] delay;
    logic [7:0]  data_byte;
    logic [23:0] rgb;
    logic [7:0]  entry_index;
    logic [15:0] top;
    logic [15:0] left;
    logic [15:0] height;
    logic [15:0] width;
  } result_t;

  // bytes in a colour table of 2^(n+1) entries
  function automatic logic [9:0] table_bytes(input logic [2:0] size_code);
    logic [9:0] entries;
    entries = 10'd2 << size_code;
    return entries + (entries << 1);
  endfunction

endpackage

`default_nettype wire

// ===== design/gif_container_block_parser.sv =====
// gif container block parser
// s_axis: one byte of a gif file per beat (tdata[7:0] = file_byte).
// m_axis: exactly one result beat per accepted byte, in order. tuser holds the
//   event code (0 when the byte produced nothing of note); tdata holds the
//   decoded fields, all zero except those belonging to the event.
// latency: a result beat is presented the cycle after its byte is accepted.
// throughput: one byte per cycle while the receiver takes each result; the whole
//   per-byte decode sits between the parser state registers and the single result register.
// s_axis_tready_o is high while the result register is empty or being taken
//   in the same cycle, so a stalled receiver holds the pending result and
//   back-pressures the byte stream after one beat; nothing is dropped.
// reset: result register empties, parser waits for the signature, the global
//   colour table flag clears. after a trailer, bad signature, missing colour
//   table or unknown block byte every further byte gives event none until
//   the next reset.
`default_nettype none

module gif_container_block_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // [7:0] file_byte
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [15:0] width, [31:16] height, [47:32] left, [63:48] top,
  // [71:64] entry_index, [95:72] rgb, [103:96] data_byte, [119:104] delay,
  // [127:120] transp_idx, [130:128] disposal, [131] transp_en
  output logic [gifp_pkg::TDATA_W-1:0] m_axis_tdata_o,
  output logic [3:0]        m_axis_tuser_o    // [3:0] event_res
);

  typedef enum logic [4:0] {
    PH_SIG       = 5'd0,
    PH_VER       = 5'd1,
    PH_LSD       = 5'd2,
    PH_GCT       = 5'd3,
    PH_BLOCK     = 5'd4,
    PH_EXT       = 5'd5,
    PH_GCE_SIZE  = 5'd6,
    PH_GCE_DATA  = 5'd7,
    PH_SKIP_LEN  = 5'd8,
    PH_SKIP_DATA = 5'd9,
    PH_ID        = 5'd10,
    PH_LCT       = 5'd11,
    PH_CODESIZE  = 5'd12,
    PH_DATA_LEN  = 5'd13,
    PH_DATA      = 5'd14,
    PH_DEAD      = 5'd15
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [9:0]       byte_cnt_q, byte_cnt_d;
  logic [9:0]       table_rem_q, table_rem_d;
  logic [8:0]       sub_rem_q, sub_rem_d;
  logic             gtp_q, gtp_d;
  logic [7:0][7:0]  fshift_q, fshift_d;
  logic [15:0]      colour_q, colour_d;
  logic [1:0]       col_q, col_d;       // byte within the current rgb triple
  logic [7:0]       entry_q, entry_d;   // colour table index
  logic             out_valid_q;
  gifp_pkg::result_t res_q, res_d;
  logic [3:0]       ev_q, ev_d;

  logic             s_accept;
  logic [7:0]       b;
  logic [9:0]       cnt_inc;
  logic [7:0][7:0]  view;               // captured bytes including this beat
  logic             capture_en;
  logic [8:0]       sub_dec;
  logic [9:0]       tbl_dec;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;
  assign cnt_inc         = byte_cnt_q + 10'd1;
  assign sub_dec         = (sub_rem_q != 9'd0) ? sub_rem_q - 9'd1 : 9'd0;
  assign tbl_dec         = (table_rem_q != 10'd0) ? table_rem_q - 10'd1 : 10'd0;

  assign capture_en = (phase_q == PH_SIG) || (phase_q == PH_LSD) ||
                      (phase_q == PH_GCE_DATA) || (phase_q == PH_ID);

  always_comb begin
    view = fshift_q;
    if (capture_en && (byte_cnt_q < 10'd8)) begin
      view[byte_cnt_q[2:0]] = b;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    byte_cnt_d  = byte_cnt_q;
    table_rem_d = table_rem_q;
    sub_rem_d   = sub_rem_q;
    gtp_d       = gtp_q;
    fshift_d    = fshift_q;
    colour_d    = colour_q;
    col_d       = col_q;
    entry_d     = entry_q;
    res_d       = '0;
    ev_d        = gifp_pkg::EV_NONE;

    case (phase_q)
      PH_SIG: begin
        fshift_d   = view;
        byte_cnt_d = cnt_inc;
        if (cnt_inc == 10'd3) begin
          byte_cnt_d = '0;
          if (view[0] == gifp_pkg::SIG_0 && view[1] == gifp_pkg::SIG_1 &&
              view[2] == gifp_pkg::SIG_2) begin
            phase_d = PH_VER;
          end else begin
            ev_d    = gifp_pkg::EV_BAD_SIG;
            phase_d = PH_DEAD;
          end
        end
      end
      PH_VER: begin
        byte_cnt_d = cnt_inc;
        if (cnt_inc == 10'd3) begin
          byte_cnt_d = '0;
          fshift_d   = '0;
          phase_d    = PH_LSD;
        end
      end
      PH_LSD: begin
        fshift_d   = view;
        byte_cnt_d = cnt_inc;
        if (cnt_inc == 10'd7) begin
          gtp_d             = view[4][7];
          ev_d              = gifp_pkg::EV_SCREEN;
          res_d.width       = {view[1], view[0]};
          res_d.height      = {view[3], view[2]};
          res_d.entry_index = view[5];
          if (view[4][7]) begin
            table_rem_d = gifp_pkg::table_bytes(view[4][2:0]);
            byte_cnt_d  = '0;
            colour_d    = '0;
            col_d       = '0;
            entry_d     = '0;
            phase_d     = PH_GCT;
          end else begin
            phase_d = PH_BLOCK;
          end
        end
      end
      PH_GCT, PH_LCT: begin
        if (col_q != 2'd2) begin
          colour_d = {colour_q[7:0], b};
          col_d    = col_q + 2'd1;
        end else begin
          ev_d              = (phase_q == PH_GCT) ? gifp_pkg::EV_GLOBAL_COL
                                                  : gifp_pkg::EV_LOCAL_COL;
          res_d.entry_index = entry_q;
          res_d.rgb         = {colour_q, b};
          col_d             = '0;
          entry_d           = entry_q + 8'd1;
        end
        table_rem_d = tbl_dec;
        if (tbl_dec == 10'd0) begin
          phase_d = (phase_q == PH_GCT) ? PH_BLOCK : PH_CODESIZE;
        end
      end
      PH_BLOCK: begin
        if (b == gifp_pkg::BYTE_EXT_INTRO) begin
          phase_d = PH_EXT;
        end else if (b == gifp_pkg::BYTE_IMG_SEP) begin
          byte_cnt_d = '0;
          fshift_d   = '0;
          phase_d    = PH_ID;
        end else if (b == gifp_pkg::BYTE_TRAILER) begin
          ev_d    = gifp_pkg::EV_TRAILER;
          phase_d = PH_DEAD;
        end else begin
          ev_d    = gifp_pkg::EV_BAD_BLOCK;
          phase_d = PH_DEAD;
        end
      end
      PH_EXT: begin
        phase_d = (b == gifp_pkg::BYTE_GCE_LABEL) ? PH_GCE_SIZE : PH_SKIP_LEN;
      end
      PH_GCE_SIZE: begin
        // block size plus its terminator
        sub_rem_d  = {1'b0, b} + 9'd1;
        byte_cnt_d = '0;
        fshift_d   = '0;
        phase_d    = PH_GCE_DATA;
      end
      PH_GCE_DATA: begin
        fshift_d = view;
        if (byte_cnt_q != 10'd1023) begin
          byte_cnt_d = cnt_inc;
        end
        sub_rem_d = sub_dec;
        if (sub_dec == 9'd0) begin
          ev_d             = gifp_pkg::EV_GCE;
          res_d.delay      = {view[2], view[1]};
          res_d.transp_idx = view[3];
          res_d.disposal   = view[0][4:2];
          res_d.transp_en  = view[0][0];
          phase_d          = PH_BLOCK;
        end
      end
      PH_SKIP_LEN: begin
        if (b == 8'd0) begin
          phase_d = PH_BLOCK;
        end else begin
          sub_rem_d = {1'b0, b};
          phase_d   = PH_SKIP_DATA;
        end
      end
      PH_SKIP_DATA: begin
        sub_rem_d = sub_dec;
        if (sub_dec == 9'd0) begin
          phase_d = PH_SKIP_LEN;
        end
      end
      PH_ID: begin
        fshift_d   = view;
        byte_cnt_d = cnt_inc;
        if (cnt_inc == 10'd9) begin
          if (!b[7] && !gtp_q) begin
            ev_d    = gifp_pkg::EV_NO_TABLE;
            phase_d = PH_DEAD;
          end else begin
            ev_d         = gifp_pkg::EV_IMAGE_DESC;
            res_d.left   = {view[1], view[0]};
            res_d.top    = {view[3], view[2]};
            res_d.width  = {view[5], view[4]};
            res_d.height = {view[7], view[6]};
            if (b[7]) begin
              table_rem_d = gifp_pkg::table_bytes(b[2:0]);
              byte_cnt_d  = '0;
              colour_d    = '0;
              col_d       = '0;
              entry_d     = '0;
              phase_d     = PH_LCT;
            end else begin
              phase_d = PH_CODESIZE;
            end
          end
        end
      end
      PH_CODESIZE: begin
        ev_d            = gifp_pkg::EV_CODE_SIZE;
        res_d.data_byte = b;
        phase_d         = PH_DATA_LEN;
      end
      PH_DATA_LEN: begin
        if (b == 8'd0) begin
          ev_d    = gifp_pkg::EV_FRAME_END;
          phase_d = PH_BLOCK;
        end else begin
          sub_rem_d = {1'b0, b};
          phase_d   = PH_DATA;
        end
      end
      PH_DATA: begin
        ev_d            = gifp_pkg::EV_DATA_BYTE;
        res_d.data_byte = b;
        sub_rem_d       = sub_dec;
        if (sub_dec == 9'd0) begin
          phase_d = PH_DATA_LEN;
        end
      end
      PH_DEAD: begin
        phase_d = PH_DEAD;
      end
      default: begin
        phase_d = PH_DEAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIG;
      byte_cnt_q  <= '0;
      table_rem_q <= '0;
      sub_rem_q   <= '0;
      gtp_q       <= 1'b0;
      fshift_q    <= '0;
      colour_q    <= '0;
      col_q       <= '0;
      entry_q     <= '0;
      out_valid_q <= 1'b0;
      ev_q        <= gifp_pkg::EV_NONE;
    end else begin
      if (s_accept) begin
        phase_q     <= phase_d;
        byte_cnt_q  <= byte_cnt_d;
        table_rem_q <= table_rem_d;
        sub_rem_q   <= sub_rem_d;
        gtp_q       <= gtp_d;
        fshift_q    <= fshift_d;
        colour_q    <= colour_d;
        col_q       <= col_d;
        entry_q     <= entry_d;
        ev_q        <= ev_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = ev_q;
  assign m_axis_tdata_o  = {4'b0, res_q};

  // a stopped parser never restarts without reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DEAD) |=> (phase_q == PH_DEAD))
    else $error("parser left the stopped phase");

  // a beat taken while stopped yields event none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && phase_q == PH_DEAD) |=> (ev_q == gifp_pkg::EV_NONE))
    else $error("event reported while stopped");

  // table phases always have bytes left to consume
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_GCT || phase_q == PH_LCT) |-> (table_rem_q != 10'd0))
    else $error("colour table phase with empty byte count");

  // rgb triple position stays within three bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q != 2'd3)
    else $error("colour byte position out of range");

  // result register is loaded whenever a beat is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> m_axis_tvalid_o)
    else $error("accepted beat produced no result");

endmodule

`default_nettype wire
